[src/bresenham_line_rasterizer_core_defines.svh]
// Assertion macros for the line rasterizer checker.
// No dependencies; included by the checker file.
`ifndef BRESENHAM_LINE_RASTERIZER_CORE_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_CORE_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted
`define BLR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define BLR_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/blr_pkg.sv]
// Shared widths, codes and beat types of the line rasterizer.
// No dependencies; used by every module of the block.
package blr_pkg;

  localparam int COORD_BITS     = 13;
  localparam int DELTA_BITS     = COORD_BITS + 1;
  localparam int ERR_BITS       = COORD_BITS + 3;
  localparam int E2_BITS        = ERR_BITS + 1;
  localparam int ADDR_BITS      = 32;
  localparam int COLOUR_BITS    = 16;
  localparam int DIM_BITS       = 13;
  localparam int PITCH_BITS     = 15;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CMP_BITS       = COORD_BITS + DIM_BITS;

  localparam logic [DIM_BITS-1:0]   RST_SCREEN_WIDTH  = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0]   RST_SCREEN_HEIGHT = DIM_BITS'(480);
  localparam logic [PITCH_BITS-1:0] RST_LINE_PITCH    = PITCH_BITS'(1280);
  localparam logic [ADDR_BITS-1:0]  RST_FRAME_BASE    = '0;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SCREEN_WIDTH  = 0,
    CFG_SCREEN_HEIGHT = 1,
    CFG_LINE_PITCH    = 2,
    CFG_FRAME_BASE    = 3
  } cfg_reg_e;

  typedef enum logic [0:0] {
    FUNC_LOAD = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    func_e                  func;
    coord_t                 start_x;
    coord_t                 start_y;
    coord_t                 end_x;
    coord_t                 end_y;
    logic [COLOUR_BITS-1:0] colour;
  } item_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]   width;
    logic [DIM_BITS-1:0]   height;
    logic [PITCH_BITS-1:0] pitch;
    logic [ADDR_BITS-1:0]  base;
  } cfg_t;

  typedef struct packed {
    logic                   valid;
    coord_t                 x;
    coord_t                 y;
    logic [COLOUR_BITS-1:0] colour;
    logic                   last;
  } pix_t;

endpackage

[src/bresenham_line_rasterizer_core.sv]
// Bresenham line rasterizer core.
// A tick beat is held in the input register, then its pixel is registered in the result register.
// Takes one beat per cycle while the result register is not stalled; the line state updates once per beat.
// Reset: no line armed, output empty, registers at 640, 480, 1280 and base 0.
// Depends on blr_pkg, blr_cfg_regs, blr_line_engine and blr_pixel_out.
module bresenham_line_rasterizer_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               func_i,
  input  blr_pkg::coord_t                    start_x_i,
  input  blr_pkg::coord_t                    start_y_i,
  input  blr_pkg::coord_t                    end_x_i,
  input  blr_pkg::coord_t                    end_y_i,
  input  logic [blr_pkg::COLOUR_BITS-1:0]    line_colour_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output blr_pkg::coord_t                    pixel_x_o,
  output blr_pkg::coord_t                    pixel_y_o,
  output logic [blr_pkg::ADDR_BITS-1:0]      pixel_address_o,
  output logic [blr_pkg::COLOUR_BITS-1:0]    pixel_colour_o,
  output logic                               write_enable_o,
  output logic                               last_pixel_o,
  input  logic                               cfg_we_i,
  input  logic [blr_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [blr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i
);

  blr_pkg::cfg_t  cfg;
  blr_pkg::pix_t  pix;
  blr_pkg::item_t item_q;
  logic           in_valid_q;
  logic           out_free, fire;

  // Advance the held beat when the result register can take it
  assign out_free   = !out_valid_o || out_ready_i;
  assign fire       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.func    <= blr_pkg::func_e'(func_i);
      item_q.start_x <= start_x_i;
      item_q.start_y <= start_y_i;
      item_q.end_x   <= end_x_i;
      item_q.end_y   <= end_y_i;
      item_q.colour  <= line_colour_i;
    end
  end

  blr_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  blr_line_engine u_line_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .pix_o  (pix)
  );

  blr_pixel_out u_pixel_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .pix_i           (pix),
    .fire_i          (fire),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_address_o (pixel_address_o),
    .pixel_colour_o  (pixel_colour_o),
    .write_enable_o  (write_enable_o),
    .last_pixel_o    (last_pixel_o)
  );

endmodule

[src/blr_cfg_regs.sv]
// Configuration register file of the line rasterizer.
// Depends on blr_pkg.
module blr_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [blr_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [blr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  output blr_pkg::cfg_t                      cfg_o
);

  blr_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write; unknown indexes leave everything alone
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        blr_pkg::CFG_SCREEN_WIDTH:  cfg_d.width  = cfg_wdata_i[blr_pkg::DIM_BITS-1:0];
        blr_pkg::CFG_SCREEN_HEIGHT: cfg_d.height = cfg_wdata_i[blr_pkg::DIM_BITS-1:0];
        blr_pkg::CFG_LINE_PITCH:    cfg_d.pitch  = cfg_wdata_i[blr_pkg::PITCH_BITS-1:0];
        blr_pkg::CFG_FRAME_BASE:    cfg_d.base   = cfg_wdata_i[blr_pkg::ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= blr_pkg::RST_SCREEN_WIDTH;
      cfg_q.height <= blr_pkg::RST_SCREEN_HEIGHT;
      cfg_q.pitch  <= blr_pkg::RST_LINE_PITCH;
      cfg_q.base   <= blr_pkg::RST_FRAME_BASE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/blr_line_engine.sv]
// Line state and Bresenham stepping: loads endpoints, emits the current pixel.
// Depends on blr_pkg.
module blr_line_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  blr_pkg::item_t item_i,
  output blr_pkg::pix_t  pix_o
);

  localparam int DB = blr_pkg::DELTA_BITS;
  localparam int EB = blr_pkg::ERR_BITS;
  localparam int E2 = blr_pkg::E2_BITS;

  blr_pkg::coord_t cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  blr_pkg::coord_t tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [DB-1:0] dx_q, dx_d, dy_q, dy_d;
  logic neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic signed [EB-1:0] err_q, err_d;
  logic [blr_pkg::COLOUR_BITS-1:0] colour_q, colour_d;
  logic active_q, active_d;

  logic signed [DB-1:0] diff_x, diff_y;
  logic [DB-1:0] abs_x, abs_y;
  logic signed [E2-1:0] e2, dx_w, dy_w, err_step;
  logic step_x, step_y, last;

  // Endpoint distances for a load
  assign diff_x = DB'(item_i.end_x) - DB'(item_i.start_x);
  assign diff_y = DB'(item_i.end_y) - DB'(item_i.start_y);
  assign abs_x  = diff_x[DB-1] ? DB'(-diff_x) : DB'(diff_x);
  assign abs_y  = diff_y[DB-1] ? DB'(-diff_y) : DB'(diff_y);

  // Error steering for a tick
  assign e2       = {err_q, 1'b0};
  assign dx_w     = $signed(E2'(dx_q));
  assign dy_w     = $signed(E2'(dy_q));
  assign step_x   = e2 >= -dy_w;
  assign step_y   = e2 <= dx_w;
  assign err_step = E2'(err_q) - (step_x ? dy_w : E2'(0)) + (step_y ? dx_w : E2'(0));
  assign last     = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    neg_x_d  = neg_x_q;
    neg_y_d  = neg_y_q;
    err_d    = err_q;
    colour_d = colour_q;
    active_d = active_q;
    if (fire_i) begin
      unique case (item_i.func)
        blr_pkg::FUNC_LOAD: begin
          cur_x_d  = item_i.start_x;
          cur_y_d  = item_i.start_y;
          tgt_x_d  = item_i.end_x;
          tgt_y_d  = item_i.end_y;
          dx_d     = abs_x;
          dy_d     = abs_y;
          neg_x_d  = diff_x[DB-1];
          neg_y_d  = diff_y[DB-1];
          err_d    = $signed(EB'(abs_x)) - $signed(EB'(abs_y));
          colour_d = item_i.colour;
          active_d = 1'b1;
        end
        blr_pkg::FUNC_TICK: begin
          if (active_q) begin
            if (last) begin
              active_d = 1'b0;
            end else begin
              err_d = EB'(err_step);
              if (step_x) begin
                cur_x_d = neg_x_q ? cur_x_q - blr_pkg::COORD_BITS'(1)
                                  : cur_x_q + blr_pkg::COORD_BITS'(1);
              end
              if (step_y) begin
                cur_y_d = neg_y_q ? cur_y_q - blr_pkg::COORD_BITS'(1)
                                  : cur_y_q + blr_pkg::COORD_BITS'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Hold the line flag under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  // Line geometry, only meaningful while a line is active
  always_ff @(posedge clk_i) begin
    cur_x_q  <= cur_x_d;
    cur_y_q  <= cur_y_d;
    tgt_x_q  <= tgt_x_d;
    tgt_y_q  <= tgt_y_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    neg_x_q  <= neg_x_d;
    neg_y_q  <= neg_y_d;
    err_q    <= err_d;
    colour_q <= colour_d;
  end

  // Current pixel; a result only on a tick with a line armed
  assign pix_o.valid  = fire_i && (item_i.func == blr_pkg::FUNC_TICK) && active_q;
  assign pix_o.x      = cur_x_q;
  assign pix_o.y      = cur_y_q;
  assign pix_o.colour = colour_q;
  assign pix_o.last   = last;

endmodule

[src/blr_pixel_out.sv]
// Address, clipping and result register of the line rasterizer.
// Depends on blr_pkg.
module blr_pixel_out (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  blr_pkg::cfg_t                         cfg_i,
  input  blr_pkg::pix_t                         pix_i,
  input  logic                                  fire_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output blr_pkg::coord_t                       pixel_x_o,
  output blr_pkg::coord_t                       pixel_y_o,
  output logic [blr_pkg::ADDR_BITS-1:0]         pixel_address_o,
  output logic [blr_pkg::COLOUR_BITS-1:0]       pixel_colour_o,
  output logic                                  write_enable_o,
  output logic                                  last_pixel_o
);

  localparam int CB = blr_pkg::COORD_BITS;
  localparam int AB = blr_pkg::ADDR_BITS;
  localparam int PB = blr_pkg::PITCH_BITS;
  localparam int MB = blr_pkg::CMP_BITS;

  logic signed [CB+PB:0] row_off;
  logic signed [CB:0]    col_off;
  logic [AB-1:0]         addr;
  logic                  on_screen;
  logic                  valid_q, valid_d;

  // Row offset y*pitch, column offset 2x, both sign extended
  assign row_off = pix_i.y * $signed({1'b0, cfg_i.pitch});
  assign col_off = $signed({pix_i.x, 1'b0});
  assign addr    = cfg_i.base + AB'(row_off) + AB'(col_off);

  // Clip against the visible area; negative coordinates fall outside
  assign on_screen = !pix_i.x[CB-1] && !pix_i.y[CB-1]
                  && (MB'(unsigned'(pix_i.x)) < MB'(cfg_i.width))
                  && (MB'(unsigned'(pix_i.y)) < MB'(cfg_i.height));

  // Load a new beat on fire, drop the old one once taken
  always_comb begin
    if (fire_i) begin
      valid_d = pix_i.valid;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && pix_i.valid) begin
      pixel_x_o       <= pix_i.x;
      pixel_y_o       <= pix_i.y;
      pixel_address_o <= addr;
      pixel_colour_o  <= pix_i.colour;
      write_enable_o  <= on_screen;
      last_pixel_o    <= pix_i.last;
    end
  end

  assign out_valid_o = valid_q;

endmodule

[src/bresenham_line_rasterizer_core_checker.sv]
// Port-level checks of the line rasterizer, bound to the top level.
// Depends on blr_pkg and bresenham_line_rasterizer_core_defines.svh.
`include "bresenham_line_rasterizer_core_defines.svh"

module bresenham_line_rasterizer_core_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input blr_pkg::coord_t               pixel_x_o,
  input blr_pkg::coord_t               pixel_y_o,
  input logic [blr_pkg::ADDR_BITS-1:0] pixel_address_o,
  input logic                          write_enable_o
);

  localparam int MSB = blr_pkg::COORD_BITS - 1;

  // A stalled result beat keeps its address
  `BLR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_address_o), "stalled pixel beat changed")

  // Input side stalls only when the result register is full and stalled
  `BLR_ASSERT(a_ready_stall, clk_i, rst_ni, !in_ready_o |-> out_valid_o && !out_ready_i, "input stalled without output backpressure")

  // An enabled write never lands at a negative coordinate
  `BLR_ASSERT(a_we_nonneg, clk_i, rst_ni, out_valid_o && write_enable_o |-> !pixel_x_o[MSB] && !pixel_y_o[MSB], "write enabled off screen")

  // No result is shown while reset is applied
  `BLR_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind bresenham_line_rasterizer_core bresenham_line_rasterizer_core_checker u_checker (.*);

[tb/sv/tb_bresenham_line_rasterizer_core.sv]
// Self-checking testbench for bresenham_line_rasterizer_core: random line
// beats with handshake gaps on both sides, checked against a local line tracer.
// Depends on blr_pkg and the rasterizer RTL.
`timescale 1ns / 100ps

module tb_bresenham_line_rasterizer_core;
  import blr_pkg::*;

  localparam int RESET_CYCLES    = 6;
  localparam int MAX_GAP         = 7;
  localparam int SETTLE_CYCLES   = 6;
  localparam int TAIL_CYCLES     = 10;
  localparam int IDLE_LIMIT      = 2000;
  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 86;
  localparam int COORD_MAX       = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN       = -(1 << (COORD_BITS - 1));
  localparam int STRAY_INDEX_LO  = int'(CFG_FRAME_BASE) + 1;
  localparam int STRAY_INDEX_HI  = (1 << CFG_INDEX_BITS) - 1;

  typedef struct packed {
    coord_t                 x;
    coord_t                 y;
    logic [ADDR_BITS-1:0]   addr;
    logic [COLOUR_BITS-1:0] colour;
    logic                   wr;
    logic                   last;
  } pixel_t;

  // Tracks the armed line and the register file, and holds the pixels
  // still owed by the block in beat order.
  class line_trace_book;
    logic [DIM_BITS-1:0]        scr_w;
    logic [DIM_BITS-1:0]        scr_h;
    logic [PITCH_BITS-1:0]      pitch;
    logic [ADDR_BITS-1:0]       base;
    coord_t                     cur_x;
    coord_t                     cur_y;
    coord_t                     tgt_x;
    coord_t                     tgt_y;
    logic signed [ERR_BITS-1:0] dist_x;
    logic signed [ERR_BITS-1:0] dist_y;
    logic signed [ERR_BITS-1:0] err;
    logic                       x_down;
    logic                       y_down;
    logic [COLOUR_BITS-1:0]     colour;
    logic                       armed;
    pixel_t                     pending_pixels[$];
    int                         errors;

    function new();
      scr_w  = RST_SCREEN_WIDTH;
      scr_h  = RST_SCREEN_HEIGHT;
      pitch  = RST_LINE_PITCH;
      base   = RST_FRAME_BASE;
      cur_x  = '0;
      cur_y  = '0;
      tgt_x  = '0;
      tgt_y  = '0;
      dist_x = '0;
      dist_y = '0;
      err    = '0;
      x_down = 1'b0;
      y_down = 1'b0;
      colour = '0;
      armed  = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_SCREEN_WIDTH:  scr_w = data[DIM_BITS-1:0];
        CFG_SCREEN_HEIGHT: scr_h = data[DIM_BITS-1:0];
        CFG_LINE_PITCH:    pitch = data[PITCH_BITS-1:0];
        CFG_FRAME_BASE:    base  = data[ADDR_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Arm a line on a load beat; emit the current pixel and step on a tick.
    function void take_beat(item_t it);
      int     cx;
      int     cy;
      int     dx;
      int     dy;
      int     e;
      int     e2;
      pixel_t px;
      if (it.func == FUNC_LOAD) begin
        cur_x  = it.start_x;
        cur_y  = it.start_y;
        tgt_x  = it.end_x;
        tgt_y  = it.end_y;
        cx     = it.start_x;
        cy     = it.start_y;
        dx     = int'(it.end_x) - cx;
        dy     = int'(it.end_y) - cy;
        x_down = dx < 0;
        y_down = dy < 0;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        dist_x = ERR_BITS'(dx);
        dist_y = ERR_BITS'(dy);
        err    = ERR_BITS'(dx - dy);
        colour = it.colour;
        armed  = 1'b1;
        return;
      end
      // Drop ticks while no line is armed
      if (!armed) return;
      cx        = cur_x;
      cy        = cur_y;
      px.x      = cur_x;
      px.y      = cur_y;
      px.addr   = base + ADDR_BITS'(cy * int'(pitch) + 2 * cx);
      px.colour = colour;
      px.wr     = cx >= 0 && cy >= 0 && cx < int'(scr_w) && cy < int'(scr_h);
      px.last   = cur_x == tgt_x && cur_y == tgt_y;
      pending_pixels.push_back(px);
      if (px.last) begin
        armed = 1'b0;
      end else begin
        // Advance along the major and minor axes by the doubled error
        dx = dist_x;
        dy = dist_y;
        e  = err;
        e2 = 2 * e;
        if (e2 >= -dy) begin
          e  -= dy;
          cx += x_down ? -1 : 1;
        end
        if (e2 <= dx) begin
          e  += dx;
          cy += y_down ? -1 : 1;
        end
        err   = ERR_BITS'(e);
        cur_x = coord_t'(cx);
        cur_y = coord_t'(cy);
      end
    endfunction

    task flag_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task match_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        flag_mismatch($sformatf("pixel (%0d,%0d) with none pending", got.x, got.y));
        return;
      end
      want = pending_pixels.pop_front();
      if (got.x !== want.x)
        flag_mismatch($sformatf("pixel_x got %0d want %0d", got.x, want.x));
      if (got.y !== want.y)
        flag_mismatch($sformatf("pixel_y got %0d want %0d", got.y, want.y));
      if (got.addr !== want.addr)
        flag_mismatch($sformatf("pixel_address got %h want %h", got.addr, want.addr));
      if (got.colour !== want.colour)
        flag_mismatch($sformatf("pixel_colour got %h want %h", got.colour, want.colour));
      if (got.wr !== want.wr)
        flag_mismatch($sformatf("write_enable got %b want %b at (%0d,%0d)",
                                got.wr, want.wr, want.x, want.y));
      if (got.last !== want.last)
        flag_mismatch($sformatf("last_pixel got %b want %b at (%0d,%0d)",
                                got.last, want.last, want.x, want.y));
    endtask
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_n = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_func = FUNC_TICK;
  coord_t                    in_start_x = '0;
  coord_t                    in_start_y = '0;
  coord_t                    in_end_x = '0;
  coord_t                    in_end_y = '0;
  logic [COLOUR_BITS-1:0]    in_colour = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  coord_t                    pix_x;
  coord_t                    pix_y;
  logic [ADDR_BITS-1:0]      pix_addr;
  logic [COLOUR_BITS-1:0]    pix_colour;
  logic                      pix_we;
  logic                      pix_last;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  line_trace_book book;
  bit             no_idle = 1'b0;
  int             beats_counted = 0;
  int             stall_left = 0;
  int             idle_count = 0;
  pixel_t         seen_pixel;

  always #5 clk_i = ~clk_i;

  bresenham_line_rasterizer_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .func_i         (in_func),
    .start_x_i      (in_start_x),
    .start_y_i      (in_start_y),
    .end_x_i        (in_end_x),
    .end_y_i        (in_end_y),
    .line_colour_i  (in_colour),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pixel_x_o      (pix_x),
    .pixel_y_o      (pix_y),
    .pixel_address_o(pix_addr),
    .pixel_colour_o (pix_colour),
    .write_enable_o (pix_we),
    .last_pixel_o   (pix_last),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata)
  );

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  function automatic int fit_coord(int v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // Mostly around the visible window, sometimes anywhere, sometimes near zero
  function automatic int near_coord(int span);
    case ($urandom_range(0, 9))
      0, 1:    return int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
      2:       return int'($urandom_range(0, 16)) - 8;
      default: return fit_coord(int'($urandom_range(0, span + 40)) - 20);
    endcase
  endfunction

  function automatic item_t load_item(int x0, int y0, int x1, int y1,
                                      logic [COLOUR_BITS-1:0] colour);
    item_t it;
    it.func    = FUNC_LOAD;
    it.start_x = coord_t'(x0);
    it.start_y = coord_t'(y0);
    it.end_x   = coord_t'(x1);
    it.end_y   = coord_t'(y1);
    it.colour  = colour;
    return it;
  endfunction

  // Tick beats carry junk in the unused fields
  function automatic item_t tick_item();
    item_t it;
    it.func    = FUNC_TICK;
    it.start_x = coord_t'($urandom);
    it.start_y = coord_t'($urandom);
    it.end_x   = coord_t'($urandom);
    it.end_y   = coord_t'($urandom);
    it.colour  = COLOUR_BITS'($urandom);
    return it;
  endfunction

  // Hold valid and payload until the beat is taken, then record it
  task automatic send_beat(input item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    in_func    <= it.func;
    in_start_x <= it.start_x;
    in_start_y <= it.start_y;
    in_end_x   <= it.end_x;
    in_end_y   <= it.end_y;
    in_colour  <= it.colour;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (it.func == FUNC_LOAD || book.armed) beats_counted++;
    book.take_beat(it);
  endtask

  // Stop sending, wait out every owed pixel, then let the pipeline settle
  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (book.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all four registers in index order, then one random index past the list
  task automatic program_regs(input logic [CFG_DATA_BITS-1:0] w, h, p, b);
    logic [CFG_DATA_BITS-1:0] vals [4];
    int                       i;
    vals = '{w, h, p, b};
    for (i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_e'(i);
      cfg_wdata <= vals[i];
      @(posedge clk_i);
      book.set_reg(cfg_reg_e'(i), vals[i]);
    end
    cfg_index <= CFG_INDEX_BITS'($urandom_range(STRAY_INDEX_LO, STRAY_INDEX_HI));
    cfg_wdata <= $urandom;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Receive pixel beats with random back-pressure
  always @(posedge clk_i) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen_pixel = '{x: pix_x, y: pix_y, addr: pix_addr, colour: pix_colour,
                       wr: pix_we, last: pix_last};
        book.match_pixel(seen_pixel);
        stall_left = draw_gap();
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_count = 0;
    end else begin
      idle_count++;
      if (idle_count >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    int phase_start;
    int x0;
    int y0;
    int x1;
    int y1;
    int reach;
    int ticks;
    int len;
    int span_x;
    int span_y;
    bit partial;

    book = new();
    rst_n <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed: tick with no line, single point, extremes, reload mid-line,
    // clipping at the screen edge, a steep line stepping toward negative x
    send_beat(tick_item());
    send_beat(load_item(0, 0, 0, 0, 16'hFFFF));
    send_beat(tick_item());
    send_beat(tick_item());
    send_beat(load_item(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 16'h0000));
    repeat (2) send_beat(tick_item());
    send_beat(load_item(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, 16'h5A5A));
    repeat (2) send_beat(tick_item());
    send_beat(load_item(639, 479, 640, 481, 16'h1234));
    repeat (4) send_beat(tick_item());
    send_beat(load_item(3, 0, 1, 5, 16'hA5A5));
    repeat (6) send_beat(tick_item());

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        no_idle = 1'b0;
        drain_pixels();
        case (phase)
          1: program_regs(32'd0, 32'd4096, 32'd2, 32'hFFFF_FFFF);
          2: program_regs(32'hFFFF_FFFF, 32'd0, 32'h0000_7FFF, 32'd0);
          3: program_regs(32'd1, 32'd1, 32'd16384, $urandom);
          4: program_regs(32'd4096, 32'd4096, $urandom_range(2, 16384), $urandom);
          5: program_regs($urandom_range(1, 64), $urandom_range(1, 64),
                          $urandom_range(2, 16384), $urandom);
          default: program_regs(32'd640, 32'd480, 32'd1280, $urandom_range(0, 255) << 12);
        endcase
      end
      span_x = (book.scr_w == 0) ? 64 : ((int'(book.scr_w) > COORD_MAX) ? COORD_MAX
                                                                        : int'(book.scr_w));
      span_y = (book.scr_h == 0) ? 64 : ((int'(book.scr_h) > COORD_MAX) ? COORD_MAX
                                                                        : int'(book.scr_h));
      phase_start = beats_counted;
      while (beats_counted - phase_start < ITEMS_PER_PHASE) begin
        no_idle = ($urandom_range(0, 4) == 0);
        x0      = near_coord(span_x);
        y0      = near_coord(span_y);
        partial = 1'b0;
        reach   = 12;
        case ($urandom_range(0, 19))
          0, 1: begin
            x1      = near_coord(span_x);
            y1      = near_coord(span_y);
            partial = 1'b1;
          end
          2:       reach = 200;
          default: reach = 12;
        endcase
        if (!partial) begin
          x1 = fit_coord(x0 + int'($urandom_range(0, 2 * reach)) - reach);
          y1 = fit_coord(y0 + int'($urandom_range(0, 2 * reach)) - reach);
        end
        len = (x1 > x0) ? x1 - x0 : x0 - x1;
        if (((y1 > y0) ? y1 - y0 : y0 - y1) > len) len = (y1 > y0) ? y1 - y0 : y0 - y1;
        len++;
        // Far lines and some short ones are cut off by the next load;
        // the rest run to the end with a few ignored ticks after it
        if (partial)
          ticks = $urandom_range(1, 8);
        else if ($urandom_range(0, 9) == 0)
          ticks = $urandom_range(1, len);
        else
          ticks = len + $urandom_range(0, 2);
        send_beat(load_item(x0, y0, x1, y1, COLOUR_BITS'($urandom)));
        repeat (ticks) send_beat(tick_item());
        if ($urandom_range(0, 15) == 0) drain_pixels();
      end
    end

    no_idle = 1'b0;
    drain_pixels();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (book.errors == 0 && book.pending_pixels.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[bresenham_line_rasterizer_core.f]
+incdir+src
src/blr_pkg.sv
src/blr_cfg_regs.sv
src/blr_line_engine.sv
src/blr_pixel_out.sv
src/bresenham_line_rasterizer_core.sv
src/bresenham_line_rasterizer_core_checker.sv
tb/sv/tb_bresenham_line_rasterizer_core.sv
